// ===== sv/two_player_game_clock_macros.svh =====
// Assertion macros for the two-player game clock.
`ifndef TWO_PLAYER_GAME_CLOCK_MACROS_SVH
`define TWO_PLAYER_GAME_CLOCK_MACROS_SVH

`ifndef SYNTHESIS

// Checked only outside reset.
`define TPGC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TPGC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TPGC_ASSERT(lbl, prop, msg)
`define TPGC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== sv/tpgc_pkg.sv =====
// Types, codes and helper functions shared by the game clock modules.
package tpgc_pkg;

	localparam logic [8:0] TOTAL_FLOOR  = 9'd60;
	localparam logic [8:0] TOTAL_MAX    = 9'd300;
	localparam logic [8:0] TOTAL_RESET  = 9'd300;
	localparam logic [2:0] INC_MAX      = 3'd5;
	localparam logic [2:0] INC_RESET    = 3'd0;
	localparam int         SECS_PER_MIN = 60;
	localparam int         MAX_MINUTES  = 8;

	localparam logic [2:0] ST_IDLE       = 3'd0;
	localparam logic [2:0] ST_RUN        = 3'd1;
	localparam logic [2:0] ST_WHITE_WINS = 3'd2;
	localparam logic [2:0] ST_BLACK_WINS = 3'd3;
	localparam logic [2:0] ST_DRAW       = 3'd4;

	localparam logic REG_TOTAL = 1'b0;
	localparam logic REG_INC   = 1'b1;

	typedef struct packed {
		logic mode;
		logic white_button;
		logic black_button;
		logic left_aux_button;
		logic right_aux_button;
	} in_word_t;

	typedef struct packed {
		logic [2:0] white_minutes;
		logic [5:0] white_secs_part;
		logic [2:0] black_minutes;
		logic [5:0] black_secs_part;
		logic [8:0] white_left;
		logic [8:0] black_left;
		logic       black_on_move;
		logic [2:0] game_status;
	} out_word_t;

	// Effective configuration, already saturated into its legal range.
	typedef struct packed {
		logic [8:0] total;
		logic [2:0] inc;
	} cfg_t;

	typedef struct packed {
		logic [8:0] white_time;
		logic [8:0] black_time;
		logic       turn_black;
		logic [2:0] status;
	} state_t;

	typedef struct packed {
		logic [2:0] minutes;
		logic [5:0] secs;
	} mmss_t;

	// Split seconds into minutes and seconds with a set of independent compares.
	function automatic mmss_t split_mmss(input logic [8:0] v);
		mmss_t      r;
		logic [3:0] q;
		logic [9:0] base;
		q    = '0;
		base = '0;
		for (int k = 1; k <= MAX_MINUTES; k++) begin
			if ({1'b0, v} >= 10'(k * SECS_PER_MIN)) begin
				q    = 4'(k);
				base = 10'(k * SECS_PER_MIN);
			end
		end
		r.minutes = q[2:0];
		r.secs    = 6'({1'b0, v} - base);
		return r;
	endfunction

	// Add the increment and clamp at the cap.
	function automatic logic [8:0] add_capped(input logic [8:0] t, input logic [2:0] inc,
			input logic [8:0] cap);
		logic [9:0] s;
		s = {1'b0, t} + {7'd0, inc};
		return (s > {1'b0, cap}) ? cap : s[8:0];
	endfunction

endpackage

// ===== sv/tpgc_cfg.sv =====
// Configuration registers with range saturation for the game clock.
module tpgc_cfg
	import tpgc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data,
	output cfg_t       cfg
);

	logic [8:0] total_q;
	logic [2:0] inc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
			inc_q   <= INC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOTAL: total_q <= cfg_data;
				REG_INC:   inc_q   <= cfg_data[2:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		if (total_q < TOTAL_FLOOR) begin
			cfg.total = TOTAL_FLOOR;
		end else if (total_q > TOTAL_MAX) begin
			cfg.total = TOTAL_MAX;
		end else begin
			cfg.total = total_q;
		end
		cfg.inc = (inc_q > INC_MAX) ? INC_MAX : inc_q;
	end

endmodule

// ===== sv/tpgc_step.sv =====
// Next-state and result logic for one clock word.
module tpgc_step
	import tpgc_pkg::*;
(
	input  in_word_t  word,
	input  state_t    cur,
	input  cfg_t      cfg,
	output state_t    nxt,
	output out_word_t res
);

	logic [8:0] shown_w;
	logic [8:0] shown_b;
	logic [8:0] wt;
	logic [8:0] bt;
	logic       tb;
	logic       ffw;
	logic       ffb;
	logic       drw;
	mmss_t      mw;
	mmss_t      mb;

	always_comb begin
		nxt = cur;
		wt  = cur.white_time;
		bt  = cur.black_time;
		tb  = cur.turn_black;
		ffw = word.white_button && word.right_aux_button;
		ffb = !ffw && word.left_aux_button && word.black_button;
		drw = !ffw && !ffb && word.left_aux_button && word.right_aux_button;

		if (word.mode) begin
			nxt.white_time = cfg.total;
			nxt.black_time = cfg.total;
			nxt.turn_black = 1'b0;
			nxt.status     = ST_RUN;
			shown_w        = cfg.total;
			shown_b        = cfg.total;
		end else begin
			shown_w = cur.white_time;
			shown_b = cur.black_time;
			if (cur.status == ST_RUN) begin
				// A move press ends that player's move before the second is charged.
				if (word.white_button) begin
					tb = 1'b1;
					wt = add_capped(wt, cfg.inc, cfg.total);
				end else if (word.black_button) begin
					tb = 1'b0;
					bt = add_capped(bt, cfg.inc, cfg.total);
				end
				if (!tb) begin
					if (wt != '0) wt = wt - 9'd1;
				end else begin
					if (bt != '0) bt = bt - 9'd1;
				end
				nxt.white_time = wt;
				nxt.black_time = bt;
				nxt.turn_black = tb;
				priority if (drw) begin
					nxt.status = ST_DRAW;
				end else if (wt == '0 || ffw) begin
					nxt.status = ST_BLACK_WINS;
				end else if (bt == '0 || ffb) begin
					nxt.status = ST_WHITE_WINS;
				end else begin
					nxt.status = ST_RUN;
				end
			end
		end

		mw = split_mmss(shown_w);
		mb = split_mmss(shown_b);

		res.white_minutes   = mw.minutes;
		res.white_secs_part = mw.secs;
		res.black_minutes   = mb.minutes;
		res.black_secs_part = mb.secs;
		res.white_left      = nxt.white_time;
		res.black_left      = nxt.black_time;
		res.black_on_move   = nxt.turn_black;
		res.game_status     = nxt.status;
	end

endmodule

// ===== sv/two_player_game_clock.sv =====
// Top level of the two-player game clock: input register, state and result register.
//
//   channel  | handshake             | word
//   ---------+-----------------------+-----------------------------
//   in       | in_valid / in_ready   | in_word  (tpgc_pkg::in_word_t)
//   out      | out_valid / out_ready | out_word (tpgc_pkg::out_word_t)
//   cfg      | cfg_we                | cfg_index, cfg_data
//
// A word passes through the input register into the result register, where its result is offered;
// one word per cycle is sustained while the result is not stalled.
// The game state updates as a word moves from the input register into the result register,
// so the following word already sees it.
// A stalled result holds the result register; the input register still takes one more word if it is empty.
// Reset clears the game to idle with zero times and loads the default configuration.

`include "two_player_game_clock_macros.svh"

module two_player_game_clock
	import tpgc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_word_t   in_word,
	output logic       out_valid,
	input  logic       out_ready,
	output out_word_t  out_word,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data
);

	in_word_t  word_s1;
	logic      valid_s1;
	state_t    st_q;
	state_t    st_nxt;
	out_word_t res;
	out_word_t out_q;
	logic      out_valid_q;
	logic      load_out;
	cfg_t      cfg;

	tpgc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tpgc_step u_step (
		.word (word_s1),
		.cur  (st_q),
		.cfg  (cfg),
		.nxt  (st_nxt),
		.res  (res)
	);

	assign load_out  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || load_out;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			st_q        <= '{white_time: '0, black_time: '0, turn_black: 1'b0, status: ST_IDLE};
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!out_valid_q || out_ready) begin
				out_valid_q <= valid_s1;
			end
			if (load_out) begin
				st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_word;
		end
		if (load_out) begin
			out_q <= res;
		end
	end

	`TPGC_ASSERT(a_ready_only_on_stall, !in_ready |-> (valid_s1 && out_valid_q && !out_ready), "input stalled without a held result")
	`TPGC_ASSERT(a_times_capped, st_q.status == ST_RUN |-> (st_q.white_time <= TOTAL_MAX && st_q.black_time <= TOTAL_MAX), "running time above the maximum total")
	`TPGC_ASSERT(a_ended_game_frozen, (load_out && !word_s1.mode && st_q.status != ST_RUN) |=> $stable(st_q), "tick changed a game that is not running")
	`TPGC_ASSERT(a_result_matches_state, $past(load_out) |-> (out_q.game_status == st_q.status && out_q.white_left == st_q.white_time), "result register out of step with game state")
	`TPGC_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (!valid_s1 && !out_valid_q), "valid flags set during reset")

endmodule
